// ===== hdl/journal_transaction_tracker_core_macros.svh =====
// Assertion helpers shared by the tracker RTL.
`ifndef JOURNAL_TRANSACTION_TRACKER_CORE_MACROS_SVH
`define JOURNAL_TRANSACTION_TRACKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define JTT_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define JTT_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jtt_pkg.sv =====
package jtt_pkg;

  localparam int BLOCK_W = 32;
  localparam int SLOT_W  = 6;
  localparam int OPS_W   = 6;
  localparam int CFG_W   = 7;

  localparam logic [OPS_W-1:0] OPS_MAX   = 6'd63;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd31;

  // input action codes
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_WAIT          = 3'd1,
    ST_LOG_FULL      = 3'd2,
    ST_OUTSIDE       = 3'd3,
    ST_COMMIT        = 3'd4,
    ST_END_NO_BEGIN  = 3'd5,
    ST_END_NO_COMMIT = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMD_BEGIN,
    CMD_END,
    CMD_WRITE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [BLOCK_W-1:0]   block;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [BLOCK_W-1:0]   block;
    logic                 absorbed;
    logic                 last;
    logic [OPS_W-1:0]     active_ops;
  } res_t;

endpackage

// ===== hdl/journal_transaction_tracker_core.sv =====
// Redo-log transaction tracker with group commit and write absorption. Each
// input beat is a begin, an end or a logged block write; each gives one result
// beat, except an end that closes the last open operation with blocks logged,
// which returns one commit beat per slot in slot order (tlast on the final one).
// An unknown action (code 3) is taken and dropped without a result.
// A front end takes beats into a two-entry queue, which registers each beat
// before the back end sees it; a back-end sequencer with a slot table (one
// write port, one registered read port) does the work. In the back end a
// begin, a rejected write, an end without commit and the first write into an
// empty table are answered straight from idle; a write into a non-empty table
// searches the entries in slot order, so a new block is appended after the
// last logged entry and an absorbed block stops at its own slot; a commit reads
// the logged blocks in slot order. A stalled result output holds the back end.
// The table needs no clearing pass after reset.
// Configuration (cfg_we/cfg_wdata) may only be written while the block is idle.
`include "journal_transaction_tracker_core_macros.svh"

module journal_transaction_tracker_core #(
  parameter int LOG_SLOTS  = 32,
  parameter int OP_RESERVE = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,      // log_area_blocks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // block_number
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // slot[5:0], committed_block[37:6],
                                      // active_ops[43:38], zero pad
  output logic [3:0]  m_axis_tuser,   // status[2:0], absorbed[3]
  output logic        m_axis_tlast    // last
);
  import jtt_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  res_t res;
  logic out_commit;
  logic out_single;
  logic single_ok;
  logic mid_list_beat;

  jtt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  jtt_back #(
    .LOG_SLOTS  (LOG_SLOTS),
    .OP_RESERVE (OP_RESERVE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {4'b0000, res.active_ops, res.block, res.slot};
  assign m_axis_tuser = {res.absorbed, res.status};
  assign m_axis_tlast = res.last;

  assign out_commit    = m_axis_tvalid && (res.status == ST_COMMIT);
  assign out_single    = m_axis_tvalid && (res.status != ST_COMMIT);
  assign single_ok     = m_axis_tlast && (!res.absorbed || res.status == ST_OK);
  assign mid_list_beat = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

  // commit beats report no open operations
  `JTT_CHK_NOW(a_commit_no_ops, out_commit, res.active_ops == '0, "commit beat with open ops")

  // only commit beats may leave the run open
  `JTT_CHK_NOW(a_single_is_last, out_single, single_ok, "single result malformed")

  // a commit list streams without gaps once a beat is taken
  `JTT_CHK_NEXT(a_commit_no_gap, mid_list_beat, m_axis_tvalid, "gap inside commit list")

endmodule

// ===== hdl/jtt_front.sv =====
module jtt_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [jtt_pkg::BLOCK_W-1:0]  s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output jtt_pkg::cmd_t                cmd
);
  import jtt_pkg::*;

  // two-entry queue toward the back end
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       keep;
  cmd_kind_t  kind;

  always_comb begin
    keep = 1'b1;
    kind = CMD_BEGIN;
    case (s_axis_tuser)
      ACT_BEGIN: kind = CMD_BEGIN;
      ACT_END:   kind = CMD_END;
      ACT_WRITE: kind = CMD_WRITE;
      default:   keep = 1'b0;  // unknown action: taken and dropped
    endcase
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign cmd_valid     = (count != 2'd0);
  assign pop           = cmd_valid && cmd_ready;
  assign cmd           = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, block: s_axis_tdata};
    end
  end

endmodule

// ===== hdl/jtt_back.sv =====
module jtt_back #(
  parameter int LOG_SLOTS  = 32,
  parameter int OP_RESERVE = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [jtt_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  jtt_pkg::cmd_t               cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output jtt_pkg::res_t               res
);
  import jtt_pkg::*;

  localparam int CNT_W  = $clog2(LOG_SLOTS + 1);
  localparam int IDX_W  = $clog2(LOG_SLOTS);
  // logged + (ops + 1) * reserve, ops + 1 at most 64
  localparam int NEED_W = $clog2(LOG_SLOTS + 64 * OP_RESERVE + 1);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   logged;
  logic [CNT_W-1:0]   logged_next;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_next;
  logic [OPS_W-1:0]   ops;
  logic [OPS_W-1:0]   ops_next;
  logic [CFG_W-1:0]   log_area_blocks;
  logic [BLOCK_W-1:0] blk;
  logic [BLOCK_W-1:0] blk_next;

  logic [BLOCK_W-1:0] mem [LOG_SLOTS];
  logic [BLOCK_W-1:0] rd_data;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [BLOCK_W-1:0] wdata;

  logic               out_free;
  logic               load;
  res_t               res_d;
  logic [NEED_W-1:0]  need;
  logic               log_full;
  logic               idx_last;
  logic               hit;

  assign out_free = !res_valid || res_ready;
  assign need     = NEED_W'(logged)
                  + NEED_W'({1'b0, ops} + 7'd1) * NEED_W'(OP_RESERVE);
  assign log_full = (logged >= CNT_W'(LOG_SLOTS))
                 || ((8'(logged) + 8'd1) >= {1'b0, log_area_blocks});
  assign idx_last = ((idx + CNT_W'(1)) == logged);
  assign hit      = (rd_data == blk);

  always_comb begin
    state_next  = state;
    logged_next = logged;
    ops_next    = ops;
    idx_next    = idx;
    blk_next    = blk;
    cmd_ready   = 1'b0;
    we          = 1'b0;
    waddr       = logged[IDX_W-1:0];
    wdata       = blk;
    load        = 1'b0;
    res_d       = '{status: ST_OK, slot: '0, block: '0, absorbed: 1'b0,
                    last: 1'b1, active_ops: ops};
    case (state)
      S_IDLE: begin
        cmd_ready = out_free;
        if (cmd_valid && out_free) begin
          blk_next = cmd.block;
          idx_next = '0;
          case (cmd.kind)
            CMD_BEGIN: begin
              load = 1'b1;
              if (ops == OPS_MAX || need > NEED_W'(LOG_SLOTS)) begin
                res_d.status = ST_WAIT;
              end else begin
                ops_next         = ops + OPS_W'(1);
                res_d.active_ops = ops + OPS_W'(1);
              end
            end
            CMD_WRITE: begin
              if (log_full) begin
                load         = 1'b1;
                res_d.status = ST_LOG_FULL;
              end else if (ops == '0) begin
                load         = 1'b1;
                res_d.status = ST_OUTSIDE;
              end else if (logged == '0) begin
                // empty table: first slot, nothing to search
                we          = 1'b1;
                waddr       = '0;
                wdata       = cmd.block;
                logged_next = CNT_W'(1);
                load        = 1'b1;
                res_d.block = cmd.block;
              end else begin
                state_next = S_SEARCH;
              end
            end
            CMD_END: begin
              if (ops == '0) begin
                load         = 1'b1;
                res_d.status = ST_END_NO_BEGIN;
              end else begin
                ops_next = ops - OPS_W'(1);
                if (ops != OPS_W'(1) || logged == '0) begin
                  load             = 1'b1;
                  res_d.status     = ST_END_NO_COMMIT;
                  res_d.active_ops = ops - OPS_W'(1);
                end else begin
                  state_next = S_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        // rd_data holds table entry idx
        if (hit) begin
          if (out_free) begin
            load           = 1'b1;
            res_d.slot     = SLOT_W'(idx);
            res_d.block    = blk;
            res_d.absorbed = 1'b1;
            state_next     = S_IDLE;
            idx_next       = '0;
          end
        end else if (idx_last) begin
          if (out_free) begin
            we          = 1'b1;
            logged_next = logged + CNT_W'(1);
            load        = 1'b1;
            res_d.slot  = SLOT_W'(logged);
            res_d.block = blk;
            state_next  = S_IDLE;
            idx_next    = '0;
          end
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load             = 1'b1;
          res_d.status     = ST_COMMIT;
          res_d.slot       = SLOT_W'(idx);
          res_d.block      = rd_data;
          res_d.last       = idx_last;
          res_d.active_ops = '0;
          if (idx_last) begin
            logged_next = '0;
            state_next  = S_IDLE;
            idx_next    = '0;
          end else begin
            idx_next = idx + CNT_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      logged          <= '0;
      ops             <= '0;
      idx             <= '0;
      log_area_blocks <= CFG_RESET;
      res_valid       <= 1'b0;
    end else begin
      state  <= state_next;
      logged <= logged_next;
      ops    <= ops_next;
      idx    <= idx_next;
      if (cfg_we) begin
        log_area_blocks <= cfg_wdata;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blk <= blk_next;
    if (load) begin
      res <= res_d;
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[idx_next[IDX_W-1:0]];
  end

endmodule
